### src/lifo_free_list_index_allocator_core_defines.svh
`ifndef LIFO_FREE_LIST_INDEX_ALLOCATOR_CORE_DEFINES_SVH
`define LIFO_FREE_LIST_INDEX_ALLOCATOR_CORE_DEFINES_SVH

// checks are sampled on i_clk and held off while i_rst_n is low
`ifndef ASSERT_OFF
`define LFIA_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);
`define LFIA_ASSERT_IMPL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
`else
`define LFIA_ASSERT_NEVER(lbl, expr, msg)
`define LFIA_ASSERT_IMPL(lbl, prop, msg)
`endif

`endif

### src/lfia_pkg.sv
`default_nettype none

package lfia_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int AW        = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    localparam int IDX_W     = 10;
    localparam int HEAP_W    = 11;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int TDATA_W   = 16;

    localparam logic [HEAP_W-1:0] IDX_SPACE = HEAP_W'(1024);
    localparam logic [HEAP_W-1:0] HEAP_RST  = HEAP_W'(1024);
    localparam logic [CNT_W-1:0]  STACK_MAX = CNT_W'(MAX_SLOTS);

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_BUMP,
        RES_POP,
        RES_EXH,
        RES_OVF
    } t_res_sel;

    typedef struct packed {
        logic     push;
        logic     pop_rd;
        logic     bump;
        logic     clear;
        logic     load;
        t_res_sel res_sel;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic exhausted;
        logic out_valid;
    } t_sts;

endpackage

`default_nettype wire

### src/lifo_free_list_index_allocator_core.sv
// result: registered the cycle after acceptance; a stack pop first passes r_rd_data and S_POP
// throughput: 1 transaction per cycle while the output register is free or drains; s_tready
//   is low in S_POP, set by the registered read port of the free stack memory
// reset: i_rst_n synchronous active low; empties the stack, clears the bump
//   counter, sets heap_size to 1024; no clearing pass, ready once reset is released
`default_nettype none

`include "lifo_free_list_index_allocator_core_defines.svh"

module lifo_free_list_index_allocator_core
    import lfia_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [HEAP_W-1:0]  i_cfg_wdata,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,  // [9:0] released_index, rest zero
    input  wire logic [OP_W-1:0]    s_tuser,  // [1:0] operation
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,  // [9:0] granted_index, rest zero
    output logic [ST_W-1:0]         m_tuser   // [1:0] status
);

    t_cmd             cmd;
    t_sts             sts;
    logic [IDX_W-1:0] granted;

    lfia_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .i_op      (s_tuser),
        .i_m_ready (m_tready),
        .i_sts     (sts),
        .o_s_ready (s_tready),
        .o_cmd     (cmd)
    );

    lfia_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rel_idx   (s_tdata[IDX_W-1:0]),
        .i_m_ready   (m_tready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_granted   (granted),
        .o_status    (m_tuser),
        .o_valid     (m_tvalid)
    );

    assign m_tdata = {{(TDATA_W-IDX_W){1'b0}}, granted};

    `LFIA_ASSERT_NEVER(a_pop_empty, cmd.pop_rd && sts.empty, "pop from empty free stack")
    `LFIA_ASSERT_NEVER(a_push_full, cmd.push && sts.full, "push onto full free stack")
    `LFIA_ASSERT_IMPL(a_pop_loads, cmd.pop_rd |=> (cmd.load && !s_tready),
        "stack pop not completed in the following cycle")
    `LFIA_ASSERT_IMPL(a_result_out, (s_tvalid && s_tready && !cmd.pop_rd) |=> m_tvalid,
        "accepted transaction produced no result")

endmodule

`default_nettype wire

### src/lfia_ctrl.sv
`default_nettype none

module lfia_ctrl
    import lfia_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_valid,
    input  wire logic [OP_W-1:0] i_op,
    input  wire logic            i_m_ready,
    input  wire t_sts            i_sts,
    output logic                 o_s_ready,
    output t_cmd                 o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '{push: 1'b0, pop_rd: 1'b0, bump: 1'b0, clear: 1'b0,
                      load: 1'b0, res_sel: RES_ZERO};
        // output register is free or drains this cycle
        o_s_ready = (r_state == S_IDLE) && (!i_sts.out_valid || i_m_ready);
        accept    = i_s_valid && o_s_ready;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        OP_ALLOC: begin
                            if (!i_sts.empty) begin
                                // stack read is registered, the result is loaded in S_POP
                                o_cmd.pop_rd = 1'b1;
                                n_state      = S_POP;
                            end else if (i_sts.exhausted) begin
                                o_cmd.load    = 1'b1;
                                o_cmd.res_sel = RES_EXH;
                            end else begin
                                o_cmd.bump    = 1'b1;
                                o_cmd.load    = 1'b1;
                                o_cmd.res_sel = RES_BUMP;
                            end
                        end
                        OP_RELEASE: begin
                            o_cmd.load = 1'b1;
                            if (i_sts.full) begin
                                o_cmd.res_sel = RES_OVF;
                            end else begin
                                o_cmd.push    = 1'b1;
                                o_cmd.res_sel = RES_ZERO;
                            end
                        end
                        OP_RESET: begin
                            o_cmd.clear   = 1'b1;
                            o_cmd.load    = 1'b1;
                            o_cmd.res_sel = RES_ZERO;
                        end
                        default: begin
                            o_cmd.load    = 1'b1;
                            o_cmd.res_sel = RES_ZERO;
                        end
                    endcase
                end
            end
            S_POP: begin
                o_cmd.load    = 1'b1;
                o_cmd.res_sel = RES_POP;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/lfia_datapath.sv
`default_nettype none

module lfia_datapath
    import lfia_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [HEAP_W-1:0] i_cfg_wdata,
    input  wire logic [IDX_W-1:0]  i_rel_idx,
    input  wire logic              i_m_ready,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    output logic [IDX_W-1:0]       o_granted,
    output logic [ST_W-1:0]        o_status,
    output logic                   o_valid
);

    logic [IDX_W-1:0]  r_stack [MAX_SLOTS];
    logic [IDX_W-1:0]  r_rd_data;
    logic [HEAP_W-1:0] r_heap;
    logic [HEAP_W-1:0] r_bump;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_granted;
    logic [ST_W-1:0]   r_status;
    logic              r_out_valid;

    logic [HEAP_W-1:0] limit;
    logic [CNT_W-1:0]  top_idx;
    logic [IDX_W-1:0]  n_granted;
    logic [ST_W-1:0]   n_status;

    assign limit   = (r_heap > IDX_SPACE) ? IDX_SPACE : r_heap;
    assign top_idx = r_count - CNT_W'(1);

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.full      = (r_count >= STACK_MAX);
    assign o_sts.exhausted = (r_bump >= limit);
    assign o_sts.out_valid = r_out_valid;

    // free stack storage, one access per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[r_count[AW-1:0]] <= i_rel_idx;
        end
        if (i_cmd.pop_rd) begin
            r_rd_data <= r_stack[top_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap  <= HEAP_RST;
            r_bump  <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_heap <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_bump  <= '0;
                r_count <= '0;
            end else begin
                if (i_cmd.bump) begin
                    r_bump <= r_bump + HEAP_W'(1);
                end
                if (i_cmd.push) begin
                    r_count <= r_count + CNT_W'(1);
                end else if (i_cmd.pop_rd) begin
                    r_count <= top_idx;
                end
            end
        end
    end

    always_comb begin
        unique case (i_cmd.res_sel)
            RES_BUMP: begin
                n_granted = r_bump[IDX_W-1:0];
                n_status  = ST_OK;
            end
            RES_POP: begin
                n_granted = r_rd_data;
                n_status  = ST_OK;
            end
            RES_EXH: begin
                n_granted = '0;
                n_status  = ST_EXHAUSTED;
            end
            RES_OVF: begin
                n_granted = '0;
                n_status  = ST_OVERFLOW;
            end
            default: begin
                n_granted = '0;
                n_status  = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_granted <= n_granted;
            r_status  <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_granted = r_granted;
    assign o_status  = r_status;
    assign o_valid   = r_out_valid;

endmodule

`default_nettype wire

### test/tb_lifo_free_list_index_allocator_core.sv
module tb_lifo_free_list_index_allocator_core;
    import lfia_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // operation code the block answers with a zero result and no state change
    localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int SEG_ITEMS   = 105;

    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        logic [ST_W-1:0]  status;
    } t_grant;

    class grant_scoreboard;
        logic [HEAP_W-1:0] heap_size;
        logic [HEAP_W-1:0] bump_next;
        logic [CNT_W-1:0]  free_depth;
        logic [IDX_W-1:0]  free_slots [MAX_SLOTS];
        t_grant            pending_grants [$];
        int errors;
        int requests;
        int grants;
        int exhausted;
        int overflows;
        int heap_writes;

        function new();
            heap_size   = HEAP_RST;
            errors      = 0;
            requests    = 0;
            grants      = 0;
            exhausted   = 0;
            overflows   = 0;
            heap_writes = 0;
            clear_allocator();
        endfunction

        function void clear_allocator();
            bump_next  = '0;
            free_depth = '0;
        endfunction

        function void set_heap_size(logic [HEAP_W-1:0] value);
            heap_size = value;
            heap_writes++;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
            t_grant            g;
            logic [HEAP_W-1:0] limit;
            g     = '0;
            limit = (heap_size > IDX_SPACE) ? IDX_SPACE : heap_size;
            requests++;
            case (op)
                OP_ALLOC: begin
                    if (free_depth != 0) begin
                        free_depth--;
                        g.granted_index = free_slots[free_depth[AW-1:0]];
                        grants++;
                    end else if (bump_next >= limit) begin
                        g.status = ST_EXHAUSTED;
                        exhausted++;
                    end else begin
                        g.granted_index = bump_next[IDX_W-1:0];
                        bump_next++;
                        grants++;
                    end
                end
                OP_RELEASE: begin
                    if (free_depth >= STACK_MAX) begin
                        g.status = ST_OVERFLOW;
                        overflows++;
                    end else begin
                        free_slots[free_depth[AW-1:0]] = idx;
                        free_depth++;
                    end
                end
                OP_RESET: begin
                    clear_allocator();
                end
                default: begin
                end
            endcase
            pending_grants.push_back(g);
        endfunction

        function void check_grant(logic [IDX_W-1:0] granted, logic [ST_W-1:0] status);
            t_grant exp;
            if (pending_grants.size() == 0) begin
                $error("result with nothing pending: granted_index %0d status %0d",
                       granted, status);
                errors++;
                return;
            end
            exp = pending_grants.pop_front();
            if (exp.granted_index !== granted) begin
                $error("granted_index: expected %0d, actual %0d", exp.granted_index, granted);
                errors++;
            end
            if (exp.status !== status) begin
                $error("status: expected %0d, actual %0d", exp.status, status);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [HEAP_W-1:0]  i_cfg_wdata = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata     = '0;
    logic [OP_W-1:0]    s_tuser     = OP_ALLOC;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [ST_W-1:0]    m_tuser;

    grant_scoreboard sb = new();
    bit  idling_on   = 1'b1;
    int  stall_cycles = 0;

    lifo_free_list_index_allocator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_tready <= !idling_on || ($urandom_range(99) >= 38);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                sb.note_request(s_tuser, s_tdata[IDX_W-1:0]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_grant(m_tdata[IDX_W-1:0], m_tuser);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
        while (idling_on && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= TDATA_W'(idx);
        do @(posedge i_clk); while (!s_tready);
    endtask

    // stop sending and wait for every outstanding result plus pop latency
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending_grants.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_heap_size(logic [HEAP_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_heap_size(value);
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        int span;
        if (sb.heap_size == 0) span = 16;
        else if (sb.heap_size > IDX_SPACE) span = MAX_SLOTS;
        else span = sb.heap_size;
        // mostly return indices inside the heap (below 16 for a zero heap), sometimes anything at all
        if ($urandom_range(99) < 70) return IDX_W'($urandom_range(span - 1));
        return IDX_W'($urandom);
    endfunction

    task automatic send_random_request();
        int r;
        r = $urandom_range(99);
        if (r < 48) send_request(OP_ALLOC, IDX_W'($urandom));
        else if (r < 92) send_request(OP_RELEASE, pick_index());
        else if (r < 97) send_request(OP_RESET, IDX_W'($urandom));
        else send_request(OP_UNDEFINED, IDX_W'($urandom));
    endtask

    initial begin
        logic [HEAP_W-1:0] seg_sizes [7];

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // small heap: bump to exhaustion, unchecked releases, lifo order
        write_heap_size(HEAP_W'(4));
        repeat (5) send_request(OP_ALLOC, '0);
        send_request(OP_RELEASE, 10'h3FF);
        send_request(OP_RELEASE, 10'h2AA);
        send_request(OP_RELEASE, 10'h155);
        send_request(OP_RELEASE, 10'h155);
        repeat (5) send_request(OP_ALLOC, 10'h3FF);
        send_request(OP_UNDEFINED, 10'h3FF);
        send_request(OP_RESET, 10'h3FF);
        send_request(OP_ALLOC, '0);

        // zero heap: only the free stack can grant
        write_heap_size('0);
        send_request(OP_ALLOC, '0);
        send_request(OP_RELEASE, 10'd5);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_RESET, '0);

        seg_sizes[0] = HEAP_W'(3);
        seg_sizes[1] = HEAP_W'($urandom_range(40, 2));
        seg_sizes[2] = HEAP_W'(1);
        seg_sizes[3] = '0;
        seg_sizes[4] = IDX_SPACE;
        seg_sizes[5] = HEAP_W'($urandom_range(1024, 1));
        seg_sizes[6] = HEAP_W'(11'h7FF);
        foreach (seg_sizes[s]) begin
            write_heap_size(seg_sizes[s]);
            idling_on = (s != 3);
            for (int n = 0; n < SEG_ITEMS; n++) begin
                if (s == 1 && n == SEG_ITEMS / 2) drain_results();
                send_random_request();
            end
        end
        idling_on = 1'b1;

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("run covered %0d transactions over %0d heap size writes",
                 sb.requests, sb.heap_writes);
        $display("  %0d grants, %0d exhausted allocates, %0d stack overflows",
                 sb.grants, sb.exhausted, sb.overflows);
        if (sb.errors == 0 && sb.pending_grants.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
